// ===== rtl/c3er_pkg.sv =====
// shared constants and register codes of the 3x3 replicate-border convolution
package c3er_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int COEF_BITS_DEF  = 16;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int ROW_W        = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH    = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT   = 16'd1024;
    localparam logic [CFG_DATA_W-1:0]   RST_COEF_TOP = 48'h0;
    localparam logic [CFG_DATA_W-1:0]   RST_COEF_MID = 48'h10000;
    localparam logic [CFG_DATA_W-1:0]   RST_COEF_BOT = 48'h0;

    // result slots one pixel can release, in output order
    localparam int RES_BODY_A = 0;
    localparam int RES_BODY_B = 1;
    localparam int RES_LAST_A = 2;
    localparam int RES_LAST_B = 3;
    localparam int RES_SLOTS  = 4;

    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/c3er_if.sv =====
// pixel and result channel interfaces
interface c3er_pix_if #(
    parameter int PIXEL_BITS = c3er_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c3er_res_if #(
    parameter int OUT_BITS = 36,
    parameter int COL_BITS = 10
);
    logic                            valid;
    logic                            ready;
    logic signed [OUT_BITS-1:0]      pixel_out;
    logic [c3er_pkg::ROW_W-1:0]      out_row;
    logic [COL_BITS-1:0]             out_col;
    logic                            run_last;
    logic                            image_end;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output run_last, output image_end, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input run_last, input image_end, output ready);
endinterface

// ===== rtl/c3er_ram.sv =====
// generic single write port ram with registered read
module c3er_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/c3er_fifo.sv =====
// short register queue between the front and back parts
module c3er_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = c3er_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/c3er_front.sv =====
// front part: takes pixels, keeps line buffers and window, classifies results
module c3er_front #(
    parameter int MAX_WIDTH  = c3er_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = c3er_pkg::PIXEL_BITS_DEF,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int EW         = 9 * PIXEL_BITS + c3er_pkg::ROW_W + CW + c3er_pkg::RES_SLOTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    c3er_pix_if.sink                            pixels,
    input  logic [c3er_pkg::CFG_WIDTH_W-1:0]    cfg_width,
    input  logic [c3er_pkg::CFG_HEIGHT_W-1:0]   cfg_height,
    input  logic                                queue_full,
    output logic                                push,
    output logic [EW-1:0]                       entry
);

    localparam int PW = PIXEL_BITS;
    localparam int RW = c3er_pkg::ROW_W;
    localparam int NS = c3er_pkg::RES_SLOTS;

    logic [RW-1:0]          row_reg;
    logic [CW-1:0]          col_reg;
    logic                   a_valid_reg;
    logic signed [PW-1:0]   a_pix_reg;
    logic [RW-1:0]          a_row_reg;
    logic [CW-1:0]          a_col_reg;
    logic [NS-1:0]          a_mask_reg;
    logic                   fwd_reg;
    logic [2*PW-1:0]        fwd_data_reg;
    logic signed [PW-1:0]   win_reg [0:8];
    logic signed [PW-1:0]   win_next [0:8];

    logic [CW:0]            w_eff;
    logic [RW-1:0]          hm1;
    logic                   lastc, lastr;
    logic [NS-1:0]          mask;
    logic                   consume, advance, accept;
    logic [2*PW-1:0]        ram_q, rd_data, wr_data;
    logic signed [PW-1:0]   col_above, col_centre;
    logic [9*PW-1:0]        win_flat;

    always_comb
    begin
        if ((cfg_width == '0) || (int'(cfg_width) > MAX_WIDTH))
        begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (CW+1)'(cfg_width);
        end
    end

    assign hm1   = cfg_height - 1'b1;
    assign lastc = ({1'b0, col_reg} >= (w_eff - 1'b1));
    assign lastr = (row_reg == hm1);

    always_comb
    begin
        mask = '0;
        mask[c3er_pkg::RES_BODY_A] = (row_reg != '0) && (col_reg != '0);
        mask[c3er_pkg::RES_BODY_B] = (row_reg != '0) && lastc;
        mask[c3er_pkg::RES_LAST_A] = lastr && (col_reg != '0);
        mask[c3er_pkg::RES_LAST_B] = lastr && lastc;
    end

    assign consume      = a_valid_reg && ((a_mask_reg == '0) || !queue_full);
    assign advance      = !a_valid_reg || consume;
    assign pixels.ready = advance;
    assign accept       = pixels.valid && advance;

    // a read of the entry written in the same cycle takes the written value
    assign rd_data    = fwd_reg ? fwd_data_reg : ram_q;
    assign col_above  = (a_row_reg == '0) ? a_pix_reg : $signed(rd_data[2*PW-1:PW]);
    assign col_centre = (a_row_reg == '0) ? a_pix_reg : $signed(rd_data[PW-1:0]);
    assign wr_data    = {col_centre, a_pix_reg};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = col_above;
        win_next[5] = col_centre;
        win_next[8] = a_pix_reg;
        for (int e = 0; e < 9; e++)
        begin
            win_flat[e*PW +: PW] = win_next[e];
        end
    end

    assign entry = {win_flat, a_row_reg, a_col_reg, a_mask_reg};
    assign push  = consume && (a_mask_reg != '0);

    c3er_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (consume),
        .waddr (a_col_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            for (int e = 0; e < 9; e++)
            begin
                win_reg[e] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                a_valid_reg <= pixels.valid;
            end
            if (accept)
            begin
                fwd_reg <= consume && (col_reg == a_col_reg);
                if (lastc)
                begin
                    col_reg <= '0;
                    row_reg <= lastr ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (consume)
            begin
                for (int e = 0; e < 9; e++)
                begin
                    win_reg[e] <= win_next[e];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg    <= pixels.pixel_in;
            a_row_reg    <= row_reg;
            a_col_reg    <= col_reg;
            a_mask_reg   <= mask;
            fwd_data_reg <= wr_data;
        end
    end

endmodule

// ===== rtl/c3er_back.sv =====
// back part: expands queued windows into results, multiplies and sums
module c3er_back #(
    parameter int PIXEL_BITS = c3er_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = c3er_pkg::COEF_BITS_DEF,
    parameter int CW         = 10,
    parameter int EW         = 9 * PIXEL_BITS + c3er_pkg::ROW_W + CW + c3er_pkg::RES_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [EW-1:0]                     entry,
    input  logic                              queue_empty,
    output logic                              pop,
    input  logic [c3er_pkg::CFG_DATA_W-1:0]   coef_top,
    input  logic [c3er_pkg::CFG_DATA_W-1:0]   coef_mid,
    input  logic [c3er_pkg::CFG_DATA_W-1:0]   coef_bot,
    c3er_res_if.source                        results
);

    localparam int PW = PIXEL_BITS;
    localparam int CB = COEF_BITS;
    localparam int RW = c3er_pkg::ROW_W;
    localparam int NS = c3er_pkg::RES_SLOTS;
    localparam int MW = PW + CB;
    localparam int SW = MW + 2;
    localparam int OW = MW + 4;
    localparam int XW = (3 * CB > c3er_pkg::CFG_DATA_W) ? 3 * CB : c3er_pkg::CFG_DATA_W;
    localparam int DW = EW - NS;

    logic                 cur_valid_reg;
    logic [DW-1:0]        cur_reg;
    logic [NS-1:0]        cur_mask_reg;

    logic                 p_valid_reg;
    logic signed [MW-1:0] prod_reg [0:8];
    logic [RW-1:0]        p_row_reg;
    logic [CW-1:0]        p_col_reg;
    logic                 p_last_reg, p_end_reg;

    logic                 s_valid_reg;
    logic signed [SW-1:0] rsum_reg [0:2];
    logic [RW-1:0]        s_row_reg;
    logic [CW-1:0]        s_col_reg;
    logic                 s_last_reg, s_end_reg;

    logic                 o_valid_reg;
    logic signed [OW-1:0] o_pix_reg;
    logic [RW-1:0]        o_row_reg;
    logic [CW-1:0]        o_col_reg;
    logic                 o_last_reg, o_end_reg;

    logic                 enable, issue;
    logic [NS-1:0]        sel, rest;
    logic                 use_last, use_b;
    logic [RW-1:0]        cur_row, res_row;
    logic [CW-1:0]        cur_col, res_col;
    logic signed [PW-1:0] win [0:8];
    logic [XW-1:0]        coefx [0:2];
    logic signed [MW-1:0] prod [0:8];
    logic [1:0]           wr_sel, wc_sel;

    assign enable = !o_valid_reg || results.ready;
    assign issue  = cur_valid_reg && enable;

    assign sel  = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign rest = cur_mask_reg & ~sel;
    assign pop  = enable && !queue_empty && (!cur_valid_reg || (rest == '0));

    assign use_last = sel[c3er_pkg::RES_LAST_A] | sel[c3er_pkg::RES_LAST_B];
    assign use_b    = sel[c3er_pkg::RES_BODY_B] | sel[c3er_pkg::RES_LAST_B];
    assign cur_col  = cur_reg[CW-1:0];
    assign cur_row  = cur_reg[CW +: RW];
    assign res_row  = use_last ? cur_row : cur_row - 1'b1;
    assign res_col  = use_b ? cur_col : cur_col - 1'b1;

    assign coefx[0] = XW'(coef_top);
    assign coefx[1] = XW'(coef_mid);
    assign coefx[2] = XW'(coef_bot);

    always_comb
    begin
        wr_sel = '0;
        wc_sel = '0;
        for (int e = 0; e < 9; e++)
        begin
            win[e] = $signed(cur_reg[CW + RW + e*PW +: PW]);
        end
        for (int kr = 0; kr < 3; kr++)
        begin
            for (int kc = 0; kc < 3; kc++)
            begin
                // bottom border repeats the last row, left border the first column, right border the last
                if (use_last)
                begin
                    wr_sel = (kr == 0) ? 2'd1 : 2'd2;
                end
                else
                begin
                    wr_sel = 2'(kr);
                end
                if (kc == 0)
                begin
                    if (use_b)
                    begin
                        wc_sel = (cur_col >= CW'(1)) ? 2'd1 : 2'd2;
                    end
                    else
                    begin
                        wc_sel = (cur_col >= CW'(2)) ? 2'd0 : 2'd1;
                    end
                end
                else
                begin
                    wc_sel = use_b ? 2'd2 : 2'(kc);
                end
                prod[kr*3+kc] = MW'($signed(coefx[kr][kc*CB +: CB]))
                              * MW'(win[wr_sel*3 + wc_sel]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_mask_reg  <= '0;
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
        end
        else if (enable)
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                cur_mask_reg  <= entry[NS-1:0];
            end
            else if (issue)
            begin
                cur_valid_reg <= (rest != '0);
                cur_mask_reg  <= rest;
            end
            p_valid_reg <= cur_valid_reg;
            s_valid_reg <= p_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            if (pop)
            begin
                cur_reg <= entry[EW-1:NS];
            end
            for (int e = 0; e < 9; e++)
            begin
                prod_reg[e] <= prod[e];
            end
            p_row_reg  <= res_row;
            p_col_reg  <= res_col;
            p_last_reg <= (rest == '0);
            p_end_reg  <= sel[c3er_pkg::RES_LAST_B];
            for (int r = 0; r < 3; r++)
            begin
                rsum_reg[r] <= SW'(prod_reg[r*3]) + SW'(prod_reg[r*3+1])
                             + SW'(prod_reg[r*3+2]);
            end
            s_row_reg  <= p_row_reg;
            s_col_reg  <= p_col_reg;
            s_last_reg <= p_last_reg;
            s_end_reg  <= p_end_reg;
            o_pix_reg  <= OW'(rsum_reg[0]) + OW'(rsum_reg[1]) + OW'(rsum_reg[2]);
            o_row_reg  <= s_row_reg;
            o_col_reg  <= s_col_reg;
            o_last_reg <= s_last_reg;
            o_end_reg  <= s_end_reg;
        end
    end

    assign results.valid     = o_valid_reg;
    assign results.pixel_out = o_pix_reg;
    assign results.out_row   = o_row_reg;
    assign results.out_col   = o_col_reg;
    assign results.run_last  = o_last_reg;
    assign results.image_end = o_end_reg;

endmodule

// ===== rtl/conv3x3_edge_replicate_core.sv =====
// top level: configuration registers, front part, queue and back part
//
//  channel   dir  handshake      payload
//  pixels    in   valid/ready    pixel_in
//  results   out  valid/ready    pixel_out, out_row, out_col, run_last, image_end
//  config    in   cfg_wr_en      cfg_index, cfg_data
//
// one pixel a cycle enters while the queue has room; a pixel releasing n results holds
// the back part until all n are issued; with two rows or more, most final-row pixels release
// two results, so with a full queue it runs at half rate; per image results equal pixels
// an accepted pixel passes to its first result through the front stage (line
// ram read), queue, issue register, multiply, row sum, final sum into the output register
// reset clears counters, window and valid flags; line buffers are not cleared
// a stalled result holds in the output register while the front keeps filling the queue
module conv3x3_edge_replicate_core #(
    parameter int MAX_WIDTH  = c3er_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = c3er_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = c3er_pkg::COEF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    c3er_pix_if.sink                          pixels,
    c3er_res_if.source                        results,
    input  logic                              cfg_wr_en,
    input  logic [c3er_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c3er_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = 9 * PIXEL_BITS + c3er_pkg::ROW_W + CW + c3er_pkg::RES_SLOTS;

    logic [c3er_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [c3er_pkg::CFG_HEIGHT_W-1:0] height_reg;
    logic [c3er_pkg::CFG_DATA_W-1:0]   coef_top_reg, coef_mid_reg, coef_bot_reg;

    logic          push, pop, queue_full, queue_empty;
    logic [EW-1:0] push_entry, pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= c3er_pkg::RST_WIDTH;
            height_reg   <= c3er_pkg::RST_HEIGHT;
            coef_top_reg <= c3er_pkg::RST_COEF_TOP;
            coef_mid_reg <= c3er_pkg::RST_COEF_MID;
            coef_bot_reg <= c3er_pkg::RST_COEF_BOT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                c3er_pkg::REG_IMAGE_WIDTH:  width_reg    <= cfg_data[c3er_pkg::CFG_WIDTH_W-1:0];
                c3er_pkg::REG_IMAGE_HEIGHT: height_reg   <= cfg_data[c3er_pkg::CFG_HEIGHT_W-1:0];
                c3er_pkg::REG_COEF_TOP:     coef_top_reg <= cfg_data;
                c3er_pkg::REG_COEF_MID:     coef_mid_reg <= cfg_data;
                c3er_pkg::REG_COEF_BOT:     coef_bot_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    c3er_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .EW         (EW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    c3er_fifo #(
        .WIDTH (EW),
        .DEPTH (c3er_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .pop   (pop),
        .rdata (pop_entry),
        .full  (queue_full),
        .empty (queue_empty)
    );

    c3er_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .CW         (CW),
        .EW         (EW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (pop_entry),
        .queue_empty (queue_empty),
        .pop         (pop),
        .coef_top    (coef_top_reg),
        .coef_mid    (coef_mid_reg),
        .coef_bot    (coef_bot_reg),
        .results     (results)
    );

endmodule

// ===== dv/tb_conv3x3_edge_replicate_core.sv =====
// self-checking testbench of the streaming 3x3 replicate-border convolution
`timescale 1ns / 1ps

module tb_conv3x3_edge_replicate_core;

    typedef struct packed {
        logic signed [35:0] pixel_out;
        logic [15:0]        out_row;
        logic [9:0]         out_col;
        logic               run_last;
        logic               image_end;
    } conv_res_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [c3er_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [c3er_pkg::CFG_DATA_W-1:0] cfg_data;

    c3er_pix_if pix ();
    c3er_res_if res ();

    conv3x3_edge_replicate_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix),
        .results   (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's registers and state
    logic [10:0]        img_w;
    logic [15:0]        img_h;
    logic [47:0]        coef_row [3];
    logic signed [15:0] row_two_up [1024];
    logic signed [15:0] row_one_up [1024];
    logic signed [15:0] win [3][3];
    logic [15:0]        row_cnt;
    logic [9:0]         col_cnt;

    logic signed [15:0] pixels_to_send [$];
    conv_res_t          results_due [$];

    int  errors;
    int  pix_accepted;
    int  stall_cycles;
    int  hold_cnt;
    bit  held_once;
    bit  no_gaps;
    int  random_items;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [35:0] window_sum(input int r0, input int r1, input int r2,
                                                      input int c0, input int c1, input int c2);
        int    rs [3];
        int    cs [3];
        longint acc;
        rs = '{r0, r1, r2};
        cs = '{c0, c1, c2};
        acc = 0;
        for (int kr = 0; kr < 3; kr++)
        begin
            for (int kc = 0; kc < 3; kc++)
            begin
                acc += longint'($signed(coef_row[kr][kc*16 +: 16])) * longint'(win[rs[kr]][cs[kc]]);
            end
        end
        return acc[35:0];
    endfunction

    task automatic convolve_pixel(input logic signed [15:0] p);
        int        w;
        int        i;
        int        j;
        int        idx;
        int        ca0;
        int        cb0;
        bit        lastc;
        bit        lastr;
        logic signed [15:0] above;
        logic signed [15:0] centre;
        conv_res_t burst [$];
        conv_res_t r;
        w = img_w;
        if (w == 0 || w > 1024)
            w = 1024;
        i = row_cnt;
        j = col_cnt;
        idx = j;
        if (i == 0)
        begin
            above  = p;
            centre = p;
        end
        else
        begin
            above  = row_two_up[idx];
            centre = row_one_up[idx];
        end
        row_two_up[idx] = (i == 0) ? p : row_one_up[idx];
        row_one_up[idx] = p;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = centre;
        win[2][2] = p;
        lastc = j >= w - 1;
        lastr = row_cnt == 16'(img_h - 16'd1);
        ca0 = (j >= 2) ? 0 : 1;
        cb0 = (j >= 1) ? 1 : 2;
        r = '0;
        if (i != 0)
        begin
            if (j >= 1)
            begin
                r.pixel_out = window_sum(0, 1, 2, ca0, 1, 2);
                r.out_row = 16'(i - 1);
                r.out_col = 10'(j - 1);
                burst.push_back(r);
            end
            if (lastc)
            begin
                r.pixel_out = window_sum(0, 1, 2, cb0, 2, 2);
                r.out_row = 16'(i - 1);
                r.out_col = 10'(j);
                burst.push_back(r);
            end
        end
        if (lastr)
        begin
            if (j >= 1)
            begin
                r.pixel_out = window_sum(1, 2, 2, ca0, 1, 2);
                r.out_row = 16'(i);
                r.out_col = 10'(j - 1);
                burst.push_back(r);
            end
            if (lastc)
            begin
                r.pixel_out = window_sum(1, 2, 2, cb0, 2, 2);
                r.out_row = 16'(i);
                r.out_col = 10'(j);
                r.image_end = 1'b1;
                burst.push_back(r);
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[k])
            results_due.push_back(burst[k]);
        if (lastc)
        begin
            col_cnt = '0;
            row_cnt = lastr ? 16'd0 : 16'(i + 1);
        end
        else
        begin
            col_cnt = 10'(j + 1);
        end
    endtask

    // pixel driver and input-side prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                convolve_pixel(pix.pixel_in);
                pix_accepted++;
            end
            if (!pix.valid || pix.ready)
            begin
                if (pixels_to_send.size() > 0 && (no_gaps || $urandom_range(99) >= 25))
                begin
                    pix.valid    <= 1'b1;
                    pix.pixel_in <= pixels_to_send.pop_front();
                end
                else
                begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // result sink with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
            else if (!held_once && pix_accepted >= 30)
            begin
                held_once <= 1'b1;
                hold_cnt  <= 300;
            end
            res.ready <= (hold_cnt <= 1) && (no_gaps || $urandom_range(99) >= 25);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        conv_res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result row %0d col %0d", res.out_row, res.out_col);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (res.pixel_out !== want.pixel_out)
                begin
                    $error("pixel_out expected %0d actual %0d", want.pixel_out, res.pixel_out);
                    errors++;
                end
                if (res.out_row !== want.out_row)
                begin
                    $error("out_row expected %0d actual %0d", want.out_row, res.out_row);
                    errors++;
                end
                if (res.out_col !== want.out_col)
                begin
                    $error("out_col expected %0d actual %0d", want.out_col, res.out_col);
                    errors++;
                end
                if (res.run_last !== want.run_last)
                begin
                    $error("run_last expected %0d actual %0d", want.run_last, res.run_last);
                    errors++;
                end
                if (res.image_end !== want.image_end)
                begin
                    $error("image_end expected %0d actual %0d", want.image_end, res.image_end);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= 5000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixels_to_send.size() > 0 || pix.valid || results_due.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [c3er_pkg::CFG_IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            c3er_pkg::REG_IMAGE_WIDTH:  img_w = val[10:0];
            c3er_pkg::REG_IMAGE_HEIGHT: img_h = val[15:0];
            c3er_pkg::REG_COEF_TOP:     coef_row[0] = val;
            c3er_pkg::REG_COEF_MID:     coef_row[1] = val;
            c3er_pkg::REG_COEF_BOT:     coef_row[2] = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup_image(input int w, input int h,
                               input logic [47:0] top, input logic [47:0] mid,
                               input logic [47:0] bot);
        wait_idle();
        write_reg(c3er_pkg::REG_IMAGE_WIDTH, 48'(w));
        write_reg(c3er_pkg::REG_IMAGE_HEIGHT, 48'(h));
        write_reg(c3er_pkg::REG_COEF_TOP, top);
        write_reg(c3er_pkg::REG_COEF_MID, mid);
        write_reg(c3er_pkg::REG_COEF_BOT, bot);
    endtask

    // kind 0: random, 1: alternating extremes, 2: most negative only
    task automatic queue_image(input int kind);
        int n;
        n = ((img_w == 0 || img_w > 1024) ? 1024 : int'(img_w)) * int'(img_h);
        for (int k = 0; k < n; k++)
        begin
            case (kind)
                1:       pixels_to_send.push_back(k[0] ? 16'sh7FFF : 16'sh8000);
                2:       pixels_to_send.push_back(16'sh8000);
                default: pixels_to_send.push_back(16'($urandom));
            endcase
        end
    endtask

    function automatic logic [47:0] rand_coefs();
        if ($urandom_range(3) == 0)
            return {16'($signed(4'($urandom))), 16'($signed(4'($urandom))),
                    16'($signed(4'($urandom)))};
        return {16'($urandom), 32'($urandom)};
    endfunction

    initial begin
        int w;
        int h;
        clk          = 1'b0;
        errors       = 0;
        pix_accepted = 0;
        stall_cycles = 0;
        hold_cnt     = 0;
        held_once    = 1'b0;
        no_gaps      = 1'b0;
        random_items = 0;
        pix.valid    = 1'b0;
        pix.pixel_in = '0;
        res.ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        img_w        = c3er_pkg::RST_WIDTH;
        img_h        = c3er_pkg::RST_HEIGHT;
        coef_row[0]  = c3er_pkg::RST_COEF_TOP;
        coef_row[1]  = c3er_pkg::RST_COEF_MID;
        coef_row[2]  = c3er_pkg::RST_COEF_BOT;
        row_cnt      = '0;
        col_cnt      = '0;
        foreach (win[a, b])
            win[a][b] = '0;
        foreach (row_two_up[k])
        begin
            row_two_up[k] = '0;
            row_one_up[k] = '0;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // largest magnitudes: all most negative, then most positive coefs
        setup_image(3, 2, 48'h800080008000, 48'h800080008000, 48'h800080008000);
        queue_image(2);
        setup_image(3, 2, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF);
        queue_image(1);
        // single pixel image, then a single column and a single row
        setup_image(1, 1, c3er_pkg::RST_COEF_TOP, c3er_pkg::RST_COEF_MID,
                    c3er_pkg::RST_COEF_BOT);
        queue_image(0);
        setup_image(1, 3, rand_coefs(), rand_coefs(), rand_coefs());
        queue_image(0);
        setup_image(2, 1, rand_coefs(), rand_coefs(), rand_coefs());
        queue_image(0);

        // the long hold-off lands in this image while its first row streams in
        setup_image(16, 3, rand_coefs(), rand_coefs(), rand_coefs());
        queue_image(0);
        // streamed with no gaps at all on either side
        setup_image(12, 3, rand_coefs(), rand_coefs(), rand_coefs());
        no_gaps = 1'b1;
        queue_image(0);
        wait_idle();
        no_gaps = 1'b0;

        while (random_items < 20)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            setup_image(w, h, rand_coefs(), rand_coefs(), rand_coefs());
            // sometimes two images back to back on one setting
            repeat ($urandom_range(1, 2))
            begin
                queue_image(0);
                random_items += w * h;
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
